// ----- rtl/brle_pkg.sv -----
`default_nettype none

package brle_pkg;

	localparam int unsigned MIN_REPEAT  = 3;
	localparam int unsigned MAX_REPEAT  = 130;
	localparam int unsigned MAX_LITERAL = 128;
	localparam int unsigned STORE_AW    = $clog2(MAX_LITERAL);
	localparam int unsigned OUT_BYTES_DEF = 8;

	typedef enum logic {
		OP_APPEND = 1'b0,
		OP_FLUSH  = 1'b1
	} op_t;

endpackage

`default_nettype wire

// ----- rtl/brle_ram.sv -----
`default_nettype none

module brle_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/byte_run_length_encoder_core.sv -----
// Byte run-length encoder.
// Input stream (s_*): one request per byte. s_tuser[0] selects append (0) or
// flush (1); s_tdata[7:0] is the byte, ignored on flush.
// Output stream (m_*): packed words of the emitted run. m_tdata[63:0] holds
// up to OUT_BYTES encoded bytes, first byte in bits 7:0, unused lanes zero;
// m_tdata[67:64] is the valid byte count. m_tlast marks the final word of a run.
// A request that emits nothing leaves s_tready high. A request that emits a run
// of n encoded bytes (header plus payload, 2..129) holds s_tready low until the
// whole run is walked: the emitter walks the run one byte per cycle while the
// output is not stalled, reading the pending bytes from the 128x8 run store
// through its registered read port. The first word is offered once
// min(n, OUT_BYTES) bytes have been collected.
// A stalled m_tready holds the output word and freezes the emitter once its
// next word is complete; no data is dropped.
// Reset clears the run counters and the output valid; the run store needs no
// clearing since it is only read at entries written by the current run.
`default_nettype none

module byte_run_length_encoder_core
	import brle_pkg::*;
#(
	parameter int unsigned OUT_BYTES = OUT_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] data_byte
	input  wire logic [0:0]  s_tuser,  // [0] op
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [71:0] m_tdata,  // [63:0] out_word, [67:64] byte_count, [71:68] zero
	output      logic        m_tlast   // run_end
);

	localparam int unsigned LANE_W = (OUT_BYTES > 1) ? $clog2(OUT_BYTES) : 1;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t              state_q;
	logic [7:0]          pend_q;
	logic [1:0]          tail_q;
	logic                rep_q;
	logic [7:0]          last_q;

	logic                em_rep_q;
	logic [7:0]          em_hdr_q;
	logic [7:0]          em_val_q;
	logic [7:0]          em_n_q;
	logic [7:0]          pos_q;
	logic [LANE_W-1:0]   lane_q;
	logic [63:0]         word_q;

	logic                out_valid_q;
	logic [63:0]         out_word_q;
	logic [3:0]          out_cnt_q;
	logic                out_last_q;

	logic                in_acc;
	op_t                 in_op;
	logic [7:0]          in_byte;
	logic [1:0]          tail_inc;

	logic                ram_we;
	logic [STORE_AW-1:0] ram_waddr;
	logic [STORE_AW-1:0] ram_raddr;
	logic [7:0]          ram_rdata;

	logic [7:0]          pend_d;
	logic [1:0]          tail_d;
	logic                rep_d;
	logic                start;
	logic                st_rep;
	logic [7:0]          st_cnt;

	logic                emitting;
	logic [7:0]          cur_byte;
	logic                last_byte;
	logic                complete;
	logic                out_free;
	logic                advance;
	logic [63:0]         word_nx;

	assign in_acc  = s_tvalid && s_tready;
	assign in_op   = op_t'(s_tuser[0]);
	assign in_byte = s_tdata;
	assign s_tready = (state_q == ST_IDLE);

	assign tail_inc = (in_byte == last_q) ? (tail_q + 2'd1) : 2'd1;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pend_q[STORE_AW-1:0];
		pend_d    = pend_q;
		tail_d    = tail_q;
		rep_d     = rep_q;
		start     = 1'b0;
		st_rep    = rep_q;
		st_cnt    = pend_q;
		if (in_acc) begin
			if (in_op == OP_FLUSH) begin
				if (pend_q != 8'd0) begin
					start  = 1'b1;
					pend_d = 8'd0;
					tail_d = 2'd0;
					rep_d  = 1'b0;
				end
			end else if (pend_q == 8'd0) begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				pend_d    = 8'd1;
				tail_d    = 2'd1;
			end else if (rep_q) begin
				if (in_byte == last_q) begin
					if (pend_q + 8'd1 >= 8'(MAX_REPEAT)) begin
						start  = 1'b1;
						st_cnt = 8'(MAX_REPEAT);
						pend_d = 8'd0;
						tail_d = 2'd0;
						rep_d  = 1'b0;
					end else begin
						pend_d = pend_q + 8'd1;
					end
				end else begin
					start     = 1'b1;
					ram_we    = 1'b1;
					ram_waddr = '0;
					pend_d    = 8'd1;
					tail_d    = 2'd1;
					rep_d     = 1'b0;
				end
			end else begin
				if (tail_inc >= 2'(MIN_REPEAT)) begin
					rep_d  = 1'b1;
					pend_d = 8'(MIN_REPEAT);
					tail_d = 2'd0;
					// earlier two copies leave the literal run
					if (pend_q != 8'(MIN_REPEAT - 1)) begin
						start  = 1'b1;
						st_rep = 1'b0;
						st_cnt = pend_q - 8'(MIN_REPEAT - 1);
					end else begin
						tail_d = tail_inc;
					end
				end else begin
					ram_we = 1'b1;
					tail_d = tail_inc;
					if (pend_q + 8'd1 >= 8'(MAX_LITERAL)) begin
						start  = 1'b1;
						st_cnt = 8'(MAX_LITERAL);
						pend_d = 8'd0;
						tail_d = 2'd0;
					end else begin
						pend_d = pend_q + 8'd1;
					end
				end
			end
		end
	end

	assign emitting  = (state_q == ST_EMIT);
	assign last_byte = (pos_q == em_n_q - 8'd1);
	assign complete  = last_byte || (lane_q == LANE_W'(OUT_BYTES - 1));
	assign out_free  = !out_valid_q || m_tready;
	assign advance   = emitting && (!complete || out_free);

	always_comb begin
		if (pos_q == 8'd0) begin
			cur_byte = em_hdr_q;
		end else if (em_rep_q) begin
			cur_byte = em_val_q;
		end else begin
			cur_byte = ram_rdata;
		end
	end

	assign word_nx   = word_q | ({56'd0, cur_byte} << {lane_q, 3'b000});
	assign ram_raddr = advance ? pos_q[STORE_AW-1:0] :
		(pos_q[STORE_AW-1:0] - STORE_AW'(1));

	brle_ram #(
		.WIDTH(8),
		.DEPTH(MAX_LITERAL)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(in_byte),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= '0;
			tail_q      <= '0;
			rep_q       <= 1'b0;
			last_q      <= '0;
			em_rep_q    <= 1'b0;
			em_hdr_q    <= '0;
			em_val_q    <= '0;
			em_n_q      <= '0;
			pos_q       <= '0;
			lane_q      <= '0;
			word_q      <= '0;
			out_valid_q <= 1'b0;
			out_word_q  <= '0;
			out_cnt_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			pend_q <= pend_d;
			tail_q <= tail_d;
			rep_q  <= rep_d;
			if (in_acc && in_op == OP_APPEND) begin
				last_q <= in_byte;
			end

			if (advance && complete) begin
				out_valid_q <= 1'b1;
				out_word_q  <= word_nx;
				out_cnt_q   <= 4'(lane_q) + 4'd1;
				out_last_q  <= last_byte;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q  <= ST_EMIT;
						em_rep_q <= st_rep;
						em_hdr_q <= st_rep ? (st_cnt - 8'(MIN_REPEAT)) : (~st_cnt + 8'd1);
						em_val_q <= last_q;
						em_n_q   <= st_rep ? 8'd2 : (st_cnt + 8'd1);
						pos_q    <= '0;
						lane_q   <= '0;
						word_q   <= '0;
					end
				end
				ST_EMIT: begin
					if (advance) begin
						pos_q <= pos_q + 8'd1;
						if (complete) begin
							word_q <= '0;
							lane_q <= '0;
						end else begin
							word_q <= word_nx;
							lane_q <= lane_q + LANE_W'(1);
						end
						if (last_byte) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_cnt_q, out_word_q};
	assign m_tlast  = out_last_q;

`ifndef SYNTH
	a_repeat_len: assert property (@(posedge clk) disable iff (!arst_n)
		rep_q |-> (pend_q >= 8'(MIN_REPEAT) && pend_q < 8'(MAX_REPEAT)))
		else $error("repeat run length out of range");

	a_literal_len: assert property (@(posedge clk) disable iff (!arst_n)
		!rep_q |-> (pend_q < 8'(MAX_LITERAL)))
		else $error("literal run overflow");

	a_emit_pos: assert property (@(posedge clk) disable iff (!arst_n)
		emitting |-> (em_n_q >= 8'd2 && pos_q < em_n_q))
		else $error("emitter position past run end");

	a_full_words: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tdata[67:64] == 4'(OUT_BYTES)))
		else $error("partial word before end of run");

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_byte) |=> (m_tvalid && m_tlast && state_q == ST_IDLE))
		else $error("run end word not presented");
`endif

endmodule

`default_nettype wire
